// ----- hw/rtl/scfs_pkg.sv -----
`default_nettype none

package scfs_pkg;

    typedef logic [7:0] t_byte;

    typedef enum logic [1:0] {
        OP_STOP   = 2'd0,
        OP_INDEX  = 2'd1,
        OP_DELETE = 2'd2,
        OP_START  = 2'd3
    } t_opcode;

    localparam int unsigned FRAME_MAX = 7;

    localparam t_byte HDR_STOP   = 8'hF0;
    localparam t_byte HDR_START  = 8'hF1;
    localparam t_byte HDR_INDEX  = 8'hF3;
    localparam t_byte HDR_DELETE = 8'hF7;
    localparam t_byte SLOT_ALL   = 8'hAA;

    localparam logic [2:0] LEN_STOP   = 3'd2;
    localparam logic [2:0] LEN_INDEX  = 3'd3;
    localparam logic [2:0] LEN_DELETE = 3'd3;
    localparam logic [2:0] LEN_START  = 3'd7;

endpackage

`default_nettype wire

// ----- hw/rtl/sound_command_frame_sender_top.sv -----
// Sound command frame sender.
// Input channel (i_valid / o_stall) takes one command word: opcode, sound
// index, delete-all flag, signed left/right amplitudes and the receiver's
// not-executed level for the final byte of that frame.
// Output channel (o_valid / i_stall) gives one bus byte per word: header,
// payload (amplitudes low byte first) and the 8-bit additive checksum, which
// carries o_last_byte, o_executed and the updated error line.
// Frames are 2 (stop), 3 (index, delete) or 7 (start) bytes long.
// The first byte of a frame passes from the input register through the frame
// shift register into the output register.
// The frame shift register gives one byte per cycle while the output is not
// stalled; the next command waits in the input register and is loaded as the
// last byte leaves.
// While i_stall is high a full output register holds its byte, the frame
// stops shifting, and o_stall rises once the input register is occupied.
// Reset (synchronous, active low) empties all stages and clears the error
// line and the stored playing index.
`default_nettype none

module sound_command_frame_sender_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [7:0]         i_sound_index,
    input  wire logic               i_delete_all,
    input  wire logic signed [15:0] i_amplitude_left,
    input  wire logic signed [15:0] i_amplitude_right,
    input  wire logic               i_receiver_rejects,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [7:0]              o_bus_byte,
    output logic                    o_last_byte,
    output logic                    o_executed,
    output logic                    o_error_line
);

    // input register
    logic                   r_in_valid;
    scfs_pkg::t_opcode      r_op;
    logic [7:0]             r_idx;
    logic                   r_all;
    logic [15:0]            r_left;
    logic [15:0]            r_right;
    logic                   r_in_rej;

    // frame shift register
    logic                   r_fr_valid;
    scfs_pkg::t_byte        r_frame [scfs_pkg::FRAME_MAX];
    scfs_pkg::t_byte        n_frame [scfs_pkg::FRAME_MAX];
    logic [2:0]             r_cnt;
    logic [2:0]             n_len;
    logic                   r_rej;

    // persistent state
    logic                   r_err;
    logic [7:0]             r_playing_index;

    // output register
    logic                   r_out_valid;
    scfs_pkg::t_byte        r_out_byte;
    logic                   r_out_last;
    logic                   r_out_exec;
    logic                   r_out_err;

    logic                   in_acc;
    logic                   emit;
    logic                   fr_done;
    logic                   load;

    scfs_pkg::t_byte        body [scfs_pkg::FRAME_MAX-1];
    scfs_pkg::t_byte        sum;

    assign emit    = r_fr_valid && (!r_out_valid || !i_stall);
    assign fr_done = emit && (r_cnt == 3'd1);
    assign load    = r_in_valid && (!r_fr_valid || fr_done);
    assign o_stall = r_in_valid && !load;
    assign in_acc  = i_valid && !o_stall;

    // frame bytes and checksum of the waiting command
    always_comb begin
        for (int k = 0; k < scfs_pkg::FRAME_MAX - 1; k++) begin
            body[k] = 8'h00;
        end
        n_len = scfs_pkg::LEN_STOP;
        case (r_op)
            scfs_pkg::OP_STOP: begin
                body[0] = scfs_pkg::HDR_STOP;
                n_len   = scfs_pkg::LEN_STOP;
            end
            scfs_pkg::OP_INDEX: begin
                body[0] = scfs_pkg::HDR_INDEX;
                body[1] = r_idx;
                n_len   = scfs_pkg::LEN_INDEX;
            end
            scfs_pkg::OP_DELETE: begin
                body[0] = scfs_pkg::HDR_DELETE;
                body[1] = r_all ? scfs_pkg::SLOT_ALL : r_idx;
                n_len   = scfs_pkg::LEN_DELETE;
            end
            scfs_pkg::OP_START: begin
                body[0] = scfs_pkg::HDR_START;
                body[1] = r_idx;
                body[2] = r_left[7:0];
                body[3] = r_left[15:8];
                body[4] = r_right[7:0];
                body[5] = r_right[15:8];
                n_len   = scfs_pkg::LEN_START;
            end
            default: begin
                body[0] = scfs_pkg::HDR_STOP;
                n_len   = scfs_pkg::LEN_STOP;
            end
        endcase
        // unused body bytes are zero, so they add nothing
        sum = 8'h00;
        for (int k = 0; k < scfs_pkg::FRAME_MAX - 1; k++) begin
            sum = sum + body[k];
        end
        // checksum lands right after the last body byte
        for (int k = 0; k < scfs_pkg::FRAME_MAX; k++) begin
            if (k == int'(n_len) - 1) begin
                n_frame[k] = sum;
            end else if (k < scfs_pkg::FRAME_MAX - 1) begin
                n_frame[k] = body[k];
            end else begin
                n_frame[k] = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
        if (in_acc) begin
            r_op     <= scfs_pkg::t_opcode'(i_opcode);
            r_idx    <= i_sound_index;
            r_all    <= i_delete_all;
            r_left   <= i_amplitude_left;
            r_right  <= i_amplitude_right;
            r_in_rej <= i_receiver_rejects;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fr_valid      <= 1'b0;
            r_cnt           <= 3'd0;
            r_err           <= 1'b0;
            r_playing_index <= 8'h00;
        end else begin
            if (load) begin
                r_fr_valid <= 1'b1;
                r_cnt      <= n_len;
                if (r_op == scfs_pkg::OP_START) begin
                    r_playing_index <= r_idx;
                end
            end else if (emit) begin
                r_cnt <= r_cnt - 3'd1;
                if (fr_done) begin
                    r_fr_valid <= 1'b0;
                end
            end
            if (fr_done) begin
                r_err <= r_rej;
            end
        end
        if (load) begin
            r_frame <= n_frame;
            r_rej   <= r_in_rej;
        end else if (emit) begin
            for (int k = 0; k < scfs_pkg::FRAME_MAX - 1; k++) begin
                r_frame[k] <= r_frame[k+1];
            end
            r_frame[scfs_pkg::FRAME_MAX-1] <= 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (emit) begin
            r_out_byte <= r_frame[0];
            r_out_last <= fr_done;
            r_out_exec <= fr_done && !r_rej;
            r_out_err  <= fr_done ? r_rej : r_err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_bus_byte   = r_out_byte;
    assign o_last_byte  = r_out_last;
    assign o_executed   = r_out_exec;
    assign o_error_line = r_out_err;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 460;
    localparam int QUIET_WORDS  = 60;

    typedef struct packed {
        scfs_pkg::t_byte bus_byte;
        logic            last_byte;
        logic            executed;
        logic            error_line;
    } t_frame_word;

    class frame_checker;
        t_frame_word     expected_words[$];
        scfs_pkg::t_byte playing_index;
        logic            error_flag;
        int              errors;

        function new();
            playing_index = '0;
            error_flag    = 1'b0;
            errors        = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // build the frame of one accepted command and queue its bytes
        function void note_command(scfs_pkg::t_opcode op, scfs_pkg::t_byte idx, logic all,
                                   logic [15:0] left, logic [15:0] right,
                                   logic rejects);
            scfs_pkg::t_byte body[7];
            int              len;
            scfs_pkg::t_byte sum;
            t_frame_word     w;
            sum = '0;
            case (op)
                scfs_pkg::OP_STOP: begin
                    body[0] = scfs_pkg::HDR_STOP;
                    len     = scfs_pkg::LEN_STOP;
                end
                scfs_pkg::OP_INDEX: begin
                    body[0] = scfs_pkg::HDR_INDEX;
                    body[1] = idx;
                    len     = scfs_pkg::LEN_INDEX;
                end
                scfs_pkg::OP_DELETE: begin
                    body[0] = scfs_pkg::HDR_DELETE;
                    body[1] = all ? scfs_pkg::SLOT_ALL : idx;
                    len     = scfs_pkg::LEN_DELETE;
                end
                default: begin
                    playing_index = idx;
                    body[0] = scfs_pkg::HDR_START;
                    body[1] = idx;
                    body[2] = left[7:0];
                    body[3] = left[15:8];
                    body[4] = right[7:0];
                    body[5] = right[15:8];
                    len     = scfs_pkg::LEN_START;
                end
            endcase
            for (int i = 0; i < len - 1; i++) begin
                sum          = sum + body[i];
                w.bus_byte   = body[i];
                w.last_byte  = 1'b0;
                w.executed   = 1'b0;
                w.error_line = error_flag;
                expected_words.push_back(w);
            end
            error_flag   = rejects;
            w.bus_byte   = sum;
            w.last_byte  = 1'b1;
            w.executed   = !rejects;
            w.error_line = error_flag;
            expected_words.push_back(w);
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, exp_val, act_val);
            end
        endfunction

        function void check_word(t_frame_word got);
            t_frame_word exp_w;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, actual byte 0x%0h",
                         $time, got.bus_byte);
                return;
            end
            exp_w = expected_words.pop_front();
            compare_field("bus_byte", exp_w.bus_byte, got.bus_byte);
            compare_field("last_byte", exp_w.last_byte, got.last_byte);
            compare_field("executed", exp_w.executed, got.executed);
            compare_field("error_line", exp_w.error_line, got.error_line);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_opcode;
    logic [7:0]         i_sound_index;
    logic               i_delete_all;
    logic signed [15:0] i_amplitude_left;
    logic signed [15:0] i_amplitude_right;
    logic               i_receiver_rejects;
    logic               o_valid;
    logic               i_stall;
    logic [7:0]         o_bus_byte;
    logic               o_last_byte;
    logic               o_executed;
    logic               o_error_line;

    frame_checker sb;
    bit           quiet_tail = 1'b0;
    int           stall_left = 0;

    sound_command_frame_sender_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_opcode           (i_opcode),
        .i_sound_index      (i_sound_index),
        .i_delete_all       (i_delete_all),
        .i_amplitude_left   (i_amplitude_left),
        .i_amplitude_right  (i_amplitude_right),
        .i_receiver_rejects (i_receiver_rejects),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_bus_byte         (o_bus_byte),
        .o_last_byte        (o_last_byte),
        .o_executed         (o_executed),
        .o_error_line       (o_error_line)
    );

    always #4 i_clk = ~i_clk;

    // output side: check accepted words, stall in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left  = 0;
        end else begin
            if (o_valid && !i_stall)
                sb.check_word({o_bus_byte, o_last_byte, o_executed, o_error_line});
            if (quiet_tail) begin
                i_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_command(scfs_pkg::t_opcode op, scfs_pkg::t_byte idx, logic all,
                                logic [15:0] left, logic [15:0] right,
                                logic rejects, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_opcode           <= op;
        i_sound_index      <= idx;
        i_delete_all       <= all;
        i_amplitude_left   <= left;
        i_amplitude_right  <= right;
        i_receiver_rejects <= rejects;
        i_valid            <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_command(op, idx, all, left, right, rejects);
    endtask

    task automatic send_random(bit allow_gap);
        int gap;
        gap = (allow_gap && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        send_command(scfs_pkg::t_opcode'($urandom_range(0, 3)),
                     scfs_pkg::t_byte'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), gap);
    endtask

    task automatic drain_frames();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[sound_command_frame_sender_top] ERROR");
        $finish;
    end

    initial begin
        sb = new();
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_opcode           <= scfs_pkg::OP_STOP;
        i_sound_index      <= '0;
        i_delete_all       <= 1'b0;
        i_amplitude_left   <= '0;
        i_amplitude_right  <= '0;
        i_receiver_rejects <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every command, field extremes, rejection and recovery
        send_command(scfs_pkg::OP_STOP, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, 0);
        send_command(scfs_pkg::OP_STOP, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 0);
        send_command(scfs_pkg::OP_STOP, 8'h5A, 1'b0, 16'h1234, 16'h8765, 1'b0, 0);
        send_command(scfs_pkg::OP_INDEX, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, 0);
        send_command(scfs_pkg::OP_INDEX, 8'hFF, 1'b1, 16'hFFFF, 16'h0000, 1'b1, 3);
        send_command(scfs_pkg::OP_INDEX, 8'h0F, 1'b0, 16'h0000, 16'hFFFF, 1'b1, 0);
        send_command(scfs_pkg::OP_DELETE, 8'h55, 1'b0, 16'h0000, 16'h0000, 1'b0, 0);
        // delete every sound overrides the slot number
        send_command(scfs_pkg::OP_DELETE, 8'h12, 1'b1, 16'h0000, 16'h0000, 1'b0, 0);
        send_command(scfs_pkg::OP_DELETE, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 0);
        send_command(scfs_pkg::OP_DELETE, 8'hFF, 1'b0, 16'h0000, 16'h0000, 1'b0, 0);
        send_command(scfs_pkg::OP_START, 8'h00, 1'b0, 16'h7FFF, 16'h8000, 1'b0, 0);
        send_command(scfs_pkg::OP_START, 8'hFF, 1'b1, 16'h8000, 16'h7FFF, 1'b1, 0);
        send_command(scfs_pkg::OP_START, 8'hFF, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 2);
        send_command(scfs_pkg::OP_START, 8'h01, 1'b0, 16'h0000, 16'h0000, 1'b1, 0);
        send_command(scfs_pkg::OP_START, 8'hC3, 1'b1, 16'hFEDC, 16'h0123, 1'b0, 0);

        // hold off until the pipe is empty
        drain_frames();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2)
                drain_frames();
            if (n == RANDOM_WORDS - QUIET_WORDS)
                quiet_tail = 1'b1;
            send_random(!quiet_tail);
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (sb.pending() != 0)
            $display("%0t: %0d expected words never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[sound_command_frame_sender_top] OK");
        end else begin
            $display("[sound_command_frame_sender_top] ERROR");
        end
        $finish;
    end

endmodule
